// ===== rtl/mtrr_pkg.sv =====
package mtrr_pkg;

   // Sizes of the range register sets.
   localparam int NUM_VAR_RANGES = 8;
   localparam int PAGE_SHIFT = 12;
   localparam int FIXED_WORDS = 11;
   localparam int VAR_IDX_W = (NUM_VAR_RANGES > 1) ? $clog2(NUM_VAR_RANGES) : 1;
   localparam int VAR_CNT_W = $clog2(NUM_VAR_RANGES + 1);
   localparam int PAGE_HI_W = 64 - PAGE_SHIFT;

   // Bit of a variable mask that enables the range.
   localparam int ENABLE_BIT = 11;

   // Limits of the fixed-range regions.
   localparam logic [63:0] FIXED_64K_LIMIT = 64'h0000_0000_0008_0000;
   localparam logic [63:0] FIXED_16K_LIMIT = 64'h0000_0000_000c_0000;
   localparam logic [63:0] FIXED_4K_LIMIT = 64'h0000_0000_0010_0000;
   localparam logic [63:0] GRAN_64K_MASK = 64'h0000_0000_0000_ffff;
   localparam logic [63:0] GRAN_16K_MASK = 64'h0000_0000_0000_3fff;
   localparam logic [63:0] GRAN_4K_MASK = 64'h0000_0000_0000_0fff;
   localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

   // Request codes.
   localparam logic [1:0] REQ_LOAD_FIXED = 2'd0;
   localparam logic [1:0] REQ_LOAD_VAR = 2'd1;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_DEFAULT_TYPE = 1'b0;
   localparam logic CSR_VAR_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  entry_index;
      logic [63:0] word_or_base;
      logic [63:0] range_mask;
      logic [63:0] phys_addr;
   } mtrr_req_type;

   typedef struct packed {
      logic [7:0]  mem_type;
      logic [63:0] next_boundary;
   } mtrr_rsp_type;

   // What one variable range contributes to a lookup.
   typedef struct packed {
      logic        valid;
      logic        bound_valid;
      logic [63:0] bound;
      logic        hit;
      logic [7:0]  mem_type;
   } mtrr_cand_type;

endpackage

// ===== rtl/mtrr_memory_type_lookup.sv =====
// Load items take effect at the edge that accepts them; they give no result and keep busy low.
// A lookup below 1 MiB keeps busy high only in S_FIXED, then gives its result on the strobe.
// Other lookups walk the variable pairs in use in S_WALK, ending once no pair is left to
// issue or in the range unit, which checks one pair per cycle with a two-step pipeline.
// The next item is accepted in the cycle the result strobe shows; the receiver cannot stall.
// Synchronous active-high reset zeroes the control registers, the CSRs and all range words.
module mtrr_memory_type_lookup
   import mtrr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  mtrr_req_type req_data,
   output logic         rsp_strobe,
   output mtrr_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [7:0]   csr_wdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FIXED = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;

   localparam logic [1:0] REGION_64K = 2'd0;
   localparam logic [1:0] REGION_16K = 2'd1;
   localparam logic [1:0] REGION_4K = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [1:0]           region_ff, region_in;
   logic [63:0]          addr_ff, addr_in;
   logic [VAR_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VAR_CNT_W-1:0] limit_ff, limit_in;
   logic [63:0]          next_ff, next_in;
   logic [7:0]           type_ff, type_in;
   logic                 hit_ff, hit_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   mtrr_rsp_type         rsp_data_ff, rsp_data_in;
   logic [7:0]           default_type_ff;
   logic [3:0]           var_count_ff;

   logic [63:0]          fixed_words_ff [FIXED_WORDS];
   logic [63:0]          var_base_ff [NUM_VAR_RANGES];
   logic [63:0]          var_mask_ff [NUM_VAR_RANGES];

   logic                 accept;
   logic                 issue;
   logic [VAR_IDX_W-1:0] slot;
   logic [3:0]           word_idx;
   logic [2:0]           byte_sel;
   logic [63:0]          gran_mask;
   logic [63:0]          fixed_word;
   mtrr_cand_type        cand;

   assign accept = start && !busy;
   assign busy = (state_ff != S_IDLE);
   assign slot = cnt_ff[VAR_IDX_W-1:0];
   assign issue = (state_ff == S_WALK) && (cnt_ff < limit_ff);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_data_ff;

   // Shared range unit, fed one variable pair per cycle.
   mtrr_range_unit u_range (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .phys_addr  (addr_ff),
      .entry_base (var_base_ff[slot]),
      .entry_mask (var_mask_ff[slot]),
      .cand       (cand)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         default_type_ff <= '0;
         var_count_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEFAULT_TYPE: default_type_ff <= csr_wdata;
            CSR_VAR_COUNT:    var_count_ff <= csr_wdata[3:0];
            default:          default_type_ff <= default_type_ff;
         endcase
      end
   end

   // Range words, written by load items.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FIXED_WORDS; i++) begin
            fixed_words_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_VAR_RANGES; i++) begin
            var_base_ff[i] <= '0;
            var_mask_ff[i] <= '0;
         end
      end else if (accept) begin
         if (req_data.req_type == REQ_LOAD_FIXED && 32'(req_data.entry_index) < FIXED_WORDS) begin
            fixed_words_ff[req_data.entry_index] <= req_data.word_or_base;
         end
         if (req_data.req_type == REQ_LOAD_VAR
             && 32'(req_data.entry_index) < NUM_VAR_RANGES) begin
            var_base_ff[VAR_IDX_W'(req_data.entry_index)] <= req_data.word_or_base;
            var_mask_ff[VAR_IDX_W'(req_data.entry_index)] <= req_data.range_mask;
         end
      end
   end

   // Fixed-range word and byte selection from the latched address.
   always_comb begin
      unique case (region_ff)
         REGION_64K: begin
            word_idx = 4'd0;
            byte_sel = addr_ff[18:16];
            gran_mask = GRAN_64K_MASK;
         end
         REGION_16K: begin
            word_idx = 4'd1 + {3'd0, addr_ff[17]};
            byte_sel = addr_ff[16:14];
            gran_mask = GRAN_16K_MASK;
         end
         default: begin
            word_idx = 4'd3 + {1'b0, addr_ff[17:15]};
            byte_sel = addr_ff[14:12];
            gran_mask = GRAN_4K_MASK;
         end
      endcase
      fixed_word = fixed_words_ff[word_idx];
   end

   // Sequencer: latch a lookup, read a fixed word or walk the pairs and fold in their bounds.
   always_comb begin
      state_in = state_ff;
      region_in = region_ff;
      addr_in = addr_ff;
      cnt_in = cnt_ff;
      limit_in = limit_ff;
      next_in = next_ff;
      type_in = type_ff;
      hit_in = hit_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_data.req_type == REQ_LOOKUP) begin
               addr_in = req_data.phys_addr;
               cnt_in = '0;
               next_in = ALL_ONES;
               type_in = '0;
               hit_in = 1'b0;
               limit_in = (32'(var_count_ff) > NUM_VAR_RANGES) ?
                          VAR_CNT_W'(NUM_VAR_RANGES) : VAR_CNT_W'(var_count_ff);
               if (req_data.phys_addr < FIXED_64K_LIMIT) begin
                  region_in = REGION_64K;
                  state_in = S_FIXED;
               end else if (req_data.phys_addr < FIXED_16K_LIMIT) begin
                  region_in = REGION_16K;
                  state_in = S_FIXED;
               end else if (req_data.phys_addr < FIXED_4K_LIMIT) begin
                  region_in = REGION_4K;
                  state_in = S_FIXED;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_FIXED: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in.mem_type = fixed_word[{byte_sel, 3'b000} +: 8];
            rsp_data_in.next_boundary = (addr_ff | gran_mask) + 64'd1;
            state_in = S_IDLE;
         end
         S_WALK: begin
            if (issue) begin
               cnt_in = cnt_ff + VAR_CNT_W'(1);
            end
            if (cand.bound_valid && cand.bound < next_ff) begin
               next_in = cand.bound;
            end
            if (cand.hit && (!hit_ff || cand.mem_type < type_ff)) begin
               type_in = cand.mem_type;
               hit_in = 1'b1;
            end
            if (!issue && !cand.valid) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in.mem_type = hit_ff ? type_ff : default_type_ff;
               rsp_data_in.next_boundary = next_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         cnt_ff <= '0;
         limit_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         cnt_ff <= cnt_in;
         limit_ff <= limit_in;
      end
   end

   // Lookup payload registers.
   always_ff @(posedge clock) begin
      region_ff <= region_in;
      addr_ff <= addr_in;
      next_ff <= next_in;
      type_ff <= type_in;
      hit_ff <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   // A result strobe is never held high in consecutive cycles.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // An accepted lookup makes the block busy.
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.req_type == REQ_LOOKUP) |=> busy)
      else $error("lookup accepted without going busy");

   // The walk never passes the number of pairs in use.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (cnt_ff <= limit_ff))
      else $error("walk counter passed its limit");

   // The range unit only holds a pair while a walk is in progress.
   a_unit_in_walk: assert property (@(posedge clock) disable iff (reset)
      cand.valid |-> (state_ff == S_WALK))
      else $error("range unit active outside a walk");
`endif

endmodule

// ===== rtl/mtrr_range_unit.sv =====
module mtrr_range_unit
   import mtrr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          issue,
   input  logic [63:0]   phys_addr,
   input  logic [63:0]   entry_base,
   input  logic [63:0]   entry_mask,
   output mtrr_cand_type cand
);

   logic                 valid_ff;
   logic                 enabled_ff;
   logic                 below_ff;
   logic                 match_ff;
   logic                 no_end_ff;
   logic [63:0]          base_ff;
   logic [63:0]          size_ff;
   logic [7:0]           type_ff;

   logic [PAGE_HI_W-1:0] mask_hi;
   logic [PAGE_HI_W-1:0] low_bit;
   logic [63:0]          base_pg;
   logic [63:0]          diff;
   logic [64:0]          sum;
   logic [63:0]          range_end;

   // First step: page-aligned base, position compare, match test and range size.
   always_comb begin
      mask_hi = entry_mask[63:PAGE_SHIFT];
      low_bit = mask_hi & (~mask_hi + PAGE_HI_W'(1));
      base_pg = {entry_base[63:PAGE_SHIFT], PAGE_SHIFT'(0)};
      diff = (phys_addr ^ entry_base) & entry_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      enabled_ff <= entry_mask[ENABLE_BIT];
      below_ff <= (phys_addr < base_pg);
      match_ff <= (diff[63:PAGE_SHIFT] == '0);
      no_end_ff <= (mask_hi == '0);
      base_ff <= base_pg;
      size_ff <= {low_bit, PAGE_SHIFT'(0)};
      type_ff <= entry_base[7:0];
   end

   // Second step: range end, saturated at the top of the address space, and the candidate outputs.
   always_comb begin
      sum = {1'b0, base_ff} + {1'b0, size_ff};
      range_end = (no_end_ff || sum[64]) ? ALL_ONES : sum[63:0];
      cand.valid = valid_ff;
      cand.bound_valid = valid_ff && enabled_ff && (below_ff || match_ff);
      cand.bound = below_ff ? base_ff : range_end;
      cand.hit = valid_ff && enabled_ff && !below_ff && match_ff;
      cand.mem_type = type_ff;
   end

endmodule
